### rtl/core/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

   // Operation codes carried by the mode field of a request.
   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_CREATE  = 3'd1,
      MODE_DELETE  = 3'd2,
      MODE_SUSPEND = 3'd3,
      MODE_RESUME  = 3'd4
   } mode_type;

   localparam int unsigned TICK_W    = 16;
   localparam int unsigned SLOT_IN_W = 4;
   localparam int unsigned MASK_W    = 8;
   localparam int unsigned STEP_W    = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_DIVIDE,
      ST_NEXT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic read;
      logic step;
      logic record;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic last_step;
      logic last_slot;
   } stat_type;

endpackage

`default_nettype wire

### rtl/core/periodic_task_dispatcher_top.sv
`default_nettype none

// Periodic task dispatcher. Each request beat carries a mode: tick, create,
// delete, suspend or resume; each produces exactly one response beat with a
// fire mask (tick only) and a status bit (set when a create fails). One
// request is handled at a time. An accepted request is first executed;
// create, delete, suspend, resume and unused modes then go to the final
// state, which loads the response register. A tick instead visits every
// slot in turn: it reads the slot's period from the period table, divides
// the tick count by that period in the shared bit-serial remainder unit,
// and records the result; after the last slot it goes to the final state.
// A response waiting in the output register does not block acceptance of
// the next request; that request's own response waits in the final state
// until the output register is free.
module periodic_task_dispatcher_top #(
   parameter int unsigned TASK_SLOTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_mode,
   input  wire logic [ptd_pkg::SLOT_IN_W-1:0]     req_slot,
   input  wire logic [ptd_pkg::TICK_W-1:0]        req_period,
   input  wire logic                              req_has_handler,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ptd_pkg::MASK_W-1:0]             rsp_fire_mask,
   output logic                                   rsp_status
);

   ptd_pkg::cmd_type  cmd;
   ptd_pkg::stat_type stat;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptd_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_has_handler (req_has_handler),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_fire_mask   (rsp_fire_mask),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

### rtl/core/ptd_datapath.sv
`default_nettype none

module ptd_datapath #(
   parameter int unsigned TASK_SLOTS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [2:0]                         req_mode,
   input  wire logic [ptd_pkg::SLOT_IN_W-1:0]      req_slot,
   input  wire logic [ptd_pkg::TICK_W-1:0]         req_period,
   input  wire logic                               req_has_handler,
   input  wire ptd_pkg::cmd_type                   cmd,
   output ptd_pkg::stat_type                       stat,
   output logic [ptd_pkg::MASK_W-1:0]              rsp_fire_mask,
   output logic                                    rsp_status
);

   localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned TW     = ptd_pkg::TICK_W;

   logic [2:0]                     mode_ff, mode_in;
   logic [ptd_pkg::SLOT_IN_W-1:0]  slot_ff, slot_in;
   logic [TW-1:0]                  period_ff, period_in;
   logic                           handler_ff, handler_in;

   logic [TW-1:0]                  tick_ff, tick_in;
   logic [TASK_SLOTS-1:0]          occupied_ff, occupied_in;
   logic [TASK_SLOTS-1:0]          running_ff, running_in;
   logic [TW-1:0]                  period_mem [TASK_SLOTS];
   logic [TW-1:0]                  period_rd_ff;
   logic                           elig_ff, elig_in;

   logic [SLOT_W-1:0]              scan_ff, scan_in;
   logic [ptd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [TW:0]                    rem_ff, rem_in;
   logic [TW-1:0]                  dvd_ff, dvd_in;
   logic [ptd_pkg::MASK_W-1:0]     mask_ff, mask_in;
   logic                           status_ff, status_in;
   logic [ptd_pkg::MASK_W-1:0]     out_mask_ff, out_mask_in;
   logic                           out_status_ff, out_status_in;

   logic                           slot_ok;
   logic [SLOT_W-1:0]              slot_idx;
   logic                           create_ok;
   logic                           mem_write;
   logic [TW:0]                    shifted;
   logic                           fires;

   assign slot_ok   = 5'(slot_ff) < 5'(TASK_SLOTS);
   assign slot_idx  = slot_ff[SLOT_W-1:0];
   assign create_ok = slot_ok && handler_ff && !occupied_ff[slot_idx];
   assign mem_write = cmd.execute && (mode_ff == ptd_pkg::MODE_CREATE) && create_ok;
   assign shifted   = {rem_ff[TW-1:0], dvd_ff[TW-1]};
   assign fires     = elig_ff && (period_rd_ff != '0) && (rem_ff[TW-1:0] == '0);

   always_comb begin
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      period_in     = period_ff;
      handler_in    = handler_ff;
      tick_in       = tick_ff;
      occupied_in   = occupied_ff;
      running_in    = running_ff;
      elig_in       = elig_ff;
      scan_in       = scan_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      out_mask_in   = out_mask_ff;
      out_status_in = out_status_ff;

      if (cmd.capture) begin
         mode_in    = req_mode;
         slot_in    = req_slot;
         period_in  = req_period;
         handler_in = req_has_handler;
      end

      if (cmd.execute) begin
         status_in = 1'b0;
         mask_in   = '0;
         scan_in   = '0;
         case (mode_ff)
            ptd_pkg::MODE_TICK: begin
               tick_in = tick_ff + TW'(1);
            end
            ptd_pkg::MODE_CREATE: begin
               if (create_ok) begin
                  occupied_in[slot_idx] = 1'b1;
                  running_in[slot_idx]  = 1'b1;
               end else begin
                  status_in = 1'b1;
               end
            end
            ptd_pkg::MODE_DELETE: begin
               if (slot_ok) begin
                  occupied_in[slot_idx] = 1'b0;
               end
            end
            ptd_pkg::MODE_SUSPEND: begin
               if (slot_ok) begin
                  running_in[slot_idx] = 1'b0;
               end
            end
            ptd_pkg::MODE_RESUME: begin
               if (slot_ok) begin
                  running_in[slot_idx] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.read) begin
         elig_in = occupied_ff[scan_ff] & running_ff[scan_ff];
         rem_in  = '0;
         dvd_in  = tick_ff;
         step_in = '0;
      end

      // One restoring step of the remainder: the partial remainder stays below
      // twice the divisor, so a single compare and subtract suffices.
      if (cmd.step) begin
         if (shifted >= {1'b0, period_rd_ff}) begin
            rem_in = shifted - {1'b0, period_rd_ff};
         end else begin
            rem_in = shifted;
         end
         dvd_in  = {dvd_ff[TW-2:0], 1'b0};
         step_in = step_ff + ptd_pkg::STEP_W'(1);
      end

      if (cmd.record) begin
         for (int k = 0; k < ptd_pkg::MASK_W; k++) begin
            if (fires && (5'(scan_ff) == 5'(k))) begin
               mask_in[k] = 1'b1;
            end
         end
         scan_in = scan_ff + SLOT_W'(1);
      end

      if (cmd.load_out) begin
         out_mask_in   = mask_ff;
         out_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         occupied_ff <= '0;
         running_ff  <= '0;
      end else begin
         tick_ff     <= tick_in;
         occupied_ff <= occupied_in;
         running_ff  <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      period_ff     <= period_in;
      handler_ff    <= handler_in;
      elig_ff       <= elig_in;
      scan_ff       <= scan_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      mask_ff       <= mask_in;
      status_ff     <= status_in;
      out_mask_ff   <= out_mask_in;
      out_status_ff <= out_status_in;
   end

   // Period table: one write port at the request slot, one registered read
   // port at the scan index.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         period_mem[slot_idx] <= period_ff;
      end
      if (cmd.read) begin
         period_rd_ff <= period_mem[scan_ff];
      end
   end

   assign stat.is_tick   = (mode_ff == ptd_pkg::MODE_TICK);
   assign stat.last_step = (step_ff == '1);
   assign stat.last_slot = (scan_ff == SLOT_W'(TASK_SLOTS - 1));

   assign rsp_fire_mask = out_mask_ff;
   assign rsp_status    = out_status_ff;

endmodule

`default_nettype wire

### rtl/core/ptd_ctrl.sv
`default_nettype none

module ptd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire ptd_pkg::stat_type  stat,
   output ptd_pkg::cmd_type        cmd
);

   ptd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The output register can take a new result when it is empty or its beat
   // is leaving in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ptd_pkg::ST_EXEC;
            end
         end
         ptd_pkg::ST_EXEC: begin
            state_in = stat.is_tick ? ptd_pkg::ST_READ : ptd_pkg::ST_DONE;
         end
         ptd_pkg::ST_READ: begin
            state_in = ptd_pkg::ST_DIVIDE;
         end
         ptd_pkg::ST_DIVIDE: begin
            if (stat.last_step) begin
               state_in = ptd_pkg::ST_NEXT;
            end
         end
         ptd_pkg::ST_NEXT: begin
            state_in = stat.last_slot ? ptd_pkg::ST_DONE : ptd_pkg::ST_READ;
         end
         ptd_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ptd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ptd_pkg::ST_IDLE);
      cmd.capture  = (state_ff == ptd_pkg::ST_IDLE) && req_valid;
      cmd.execute  = (state_ff == ptd_pkg::ST_EXEC);
      cmd.read     = (state_ff == ptd_pkg::ST_READ);
      cmd.step     = (state_ff == ptd_pkg::ST_DIVIDE);
      cmd.record   = (state_ff == ptd_pkg::ST_NEXT);
      cmd.load_out = (state_ff == ptd_pkg::ST_DONE) && out_free;
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ptd_pkg::ST_EXEC))
      else $error("accepted request did not enter execution");

   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptd_pkg::ST_DIVIDE && !stat.last_step)
         |=> (state_ff == ptd_pkg::ST_DIVIDE))
      else $error("remainder unit left before its last step");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptd_pkg::ST_NEXT && stat.last_slot) |=> (state_ff == ptd_pkg::ST_DONE))
      else $error("slot scan did not finish after the last slot");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_valid_ff && state_ff == ptd_pkg::ST_IDLE))
      else $error("loaded result not presented");

endmodule

`default_nettype wire
